@@ src/tobf_pkg.sv @@
`timescale 1ns / 1ps
package tobf_pkg;

    localparam int PRICE_BITS   = 32;
    localparam int QTY_BITS     = 32;
    localparam int COUNT_BITS   = 16;
    localparam int SEQ_BITS     = 48;
    localparam int TSEQ_BITS    = 32;
    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    localparam logic SIDE_SELL = 1'b1;

    localparam logic [1:0] MSG_TRADE = 2'd0;
    localparam logic [1:0] MSG_BOOK  = 2'd1;
    localparam logic [1:0] MSG_SNAP  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SNAP_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYMBOL_ID     = 1'b1;

    localparam logic [CFG_BITS-1:0] SNAP_INTERVAL_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   quantity;
        logic                  resting_removed;
        logic [TSEQ_BITS-1:0]  trade_seq_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            msg_type;
        logic [SEQ_BITS-1:0]   msg_sequence;
        logic [CFG_BITS-1:0]   symbol;
        logic [PRICE_BITS-1:0] bid_price_out;
        logic [QTY_BITS-1:0]   bid_qty_out;
        logic [PRICE_BITS-1:0] ask_price_out;
        logic [QTY_BITS-1:0]   ask_qty_out;
        logic [PRICE_BITS-1:0] trade_price_out;
        logic [QTY_BITS-1:0]   trade_qty_out;
        logic [TSEQ_BITS-1:0]  trade_seq_out;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [PRICE_BITS-1:0] bid_px;
        logic [QTY_BITS-1:0]   bid_qty;
        logic [PRICE_BITS-1:0] ask_px;
        logic [QTY_BITS-1:0]   ask_qty;
    } t_book;

    // One classified event: what the back end has to announce.
    typedef struct packed {
        logic                  is_trade;
        logic                  updated;
        logic [PRICE_BITS-1:0] trade_price;
        logic [QTY_BITS-1:0]   trade_qty;
        logic [TSEQ_BITS-1:0]  trade_seq;
        t_book                 book_before;
        t_book                 book_after;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        PH_START,
        PH_SNAP_A,
        PH_BOOK,
        PH_SNAP_B
    } t_phase;

endpackage

@@ src/tobf_front.sv @@
`timescale 1ns / 1ps
module tobf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tobf_pkg::t_in_item  i_item,
    input  tobf_pkg::t_q_status i_q,
    output logic                o_push,
    output tobf_pkg::t_job      o_job
);
    import tobf_pkg::*;

    logic [PRICE_BITS-1:0] r_bid_px, n_bid_px, r_ask_px, n_ask_px;
    logic [QTY_BITS-1:0]   r_bid_qty, n_bid_qty, r_ask_qty, n_ask_qty;
    logic [COUNT_BITS-1:0] r_bid_ord, n_bid_ord, r_ask_ord, n_ask_ord;

    logic                  accept;
    logic                  updated;
    logic                  sell;
    logic                  dec;
    logic [QTY_BITS:0]     bid_sum, ask_sum;
    logic [QTY_BITS-1:0]   bid_add_qty, ask_add_qty, bid_sub_qty, ask_sub_qty;
    logic [COUNT_BITS-1:0] bid_inc_ord, ask_inc_ord, bid_dec_ord, ask_dec_ord;
    logic                  bid_live, ask_live, bid_hit, ask_hit;

    assign o_stall = i_q.full;
    assign accept  = i_valid && !i_q.full;
    assign sell    = (i_item.side == SIDE_SELL);
    assign dec     = (i_item.kind == KIND_TRADE) ? i_item.resting_removed : 1'b1;

    assign bid_live = (r_bid_ord != '0);
    assign ask_live = (r_ask_ord != '0);
    assign bid_hit  = bid_live && (r_bid_px == i_item.price);
    assign ask_hit  = ask_live && (r_ask_px == i_item.price);

    assign bid_sum     = {1'b0, r_bid_qty} + {1'b0, i_item.quantity};
    assign ask_sum     = {1'b0, r_ask_qty} + {1'b0, i_item.quantity};
    assign bid_add_qty = bid_sum[QTY_BITS] ? '1 : bid_sum[QTY_BITS-1:0];
    assign ask_add_qty = ask_sum[QTY_BITS] ? '1 : ask_sum[QTY_BITS-1:0];
    assign bid_sub_qty = (r_bid_qty >= i_item.quantity) ? r_bid_qty - i_item.quantity : '0;
    assign ask_sub_qty = (r_ask_qty >= i_item.quantity) ? r_ask_qty - i_item.quantity : '0;
    assign bid_inc_ord = (r_bid_ord == '1) ? r_bid_ord : r_bid_ord + 1'b1;
    assign ask_inc_ord = (r_ask_ord == '1) ? r_ask_ord : r_ask_ord + 1'b1;
    assign bid_dec_ord = dec ? r_bid_ord - 1'b1 : r_bid_ord;
    assign ask_dec_ord = dec ? r_ask_ord - 1'b1 : r_ask_ord;

    always_comb begin
        n_bid_px  = r_bid_px;
        n_bid_qty = r_bid_qty;
        n_bid_ord = r_bid_ord;
        n_ask_px  = r_ask_px;
        n_ask_qty = r_ask_qty;
        n_ask_ord = r_ask_ord;
        updated   = 1'b0;
        priority if (i_item.kind == KIND_TRADE) begin
            // The bid is matched first; a matched side is only ever consumed.
            if (bid_hit) begin
                updated   = 1'b1;
                n_bid_qty = bid_sub_qty;
                n_bid_ord = bid_dec_ord;
                if (bid_dec_ord == '0) begin
                    n_bid_px  = '0;
                    n_bid_qty = '0;
                end
            end else if (ask_hit) begin
                updated   = 1'b1;
                n_ask_qty = ask_sub_qty;
                n_ask_ord = ask_dec_ord;
                if (ask_dec_ord == '0) begin
                    n_ask_px  = '0;
                    n_ask_qty = '0;
                end
            end
        end else if (i_item.kind == KIND_ACCEPT) begin
            if (i_item.price != '0) begin
                if (!sell) begin
                    if (!(ask_live && i_item.price >= r_ask_px)) begin
                        if (!bid_live || i_item.price > r_bid_px) begin
                            updated   = 1'b1;
                            n_bid_px  = i_item.price;
                            n_bid_qty = i_item.quantity;
                            n_bid_ord = COUNT_BITS'(1);
                        end else if (i_item.price == r_bid_px) begin
                            updated   = 1'b1;
                            n_bid_qty = bid_add_qty;
                            n_bid_ord = bid_inc_ord;
                        end
                    end
                end else begin
                    if (!(bid_live && i_item.price <= r_bid_px)) begin
                        if (!ask_live || i_item.price < r_ask_px) begin
                            updated   = 1'b1;
                            n_ask_px  = i_item.price;
                            n_ask_qty = i_item.quantity;
                            n_ask_ord = COUNT_BITS'(1);
                        end else if (i_item.price == r_ask_px) begin
                            updated   = 1'b1;
                            n_ask_qty = ask_add_qty;
                            n_ask_ord = ask_inc_ord;
                        end
                    end
                end
            end
        end else if (i_item.kind == KIND_CANCEL) begin
            if (!sell && bid_hit) begin
                updated   = 1'b1;
                n_bid_qty = bid_sub_qty;
                n_bid_ord = bid_dec_ord;
                if (bid_dec_ord == '0) begin
                    n_bid_px  = '0;
                    n_bid_qty = '0;
                end
            end else if (sell && ask_hit) begin
                updated   = 1'b1;
                n_ask_qty = ask_sub_qty;
                n_ask_ord = ask_dec_ord;
                if (ask_dec_ord == '0) begin
                    n_ask_px  = '0;
                    n_ask_qty = '0;
                end
            end
        end else begin
            // An unknown kind leaves the book as it is.
            updated = 1'b0;
        end
    end

    assign o_push = accept && ((i_item.kind == KIND_TRADE) || updated);

    always_comb begin
        o_job.is_trade              = (i_item.kind == KIND_TRADE);
        o_job.updated               = updated;
        o_job.trade_price           = i_item.price;
        o_job.trade_qty             = i_item.quantity;
        o_job.trade_seq             = i_item.trade_seq_in;
        o_job.book_before.bid_px    = r_bid_px;
        o_job.book_before.bid_qty   = r_bid_qty;
        o_job.book_before.ask_px    = r_ask_px;
        o_job.book_before.ask_qty   = r_ask_qty;
        o_job.book_after.bid_px     = n_bid_px;
        o_job.book_after.bid_qty    = n_bid_qty;
        o_job.book_after.ask_px     = n_ask_px;
        o_job.book_after.ask_qty    = n_ask_qty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_px  <= '0;
            r_bid_qty <= '0;
            r_bid_ord <= '0;
            r_ask_px  <= '0;
            r_ask_qty <= '0;
            r_ask_ord <= '0;
        end else if (accept) begin
            r_bid_px  <= n_bid_px;
            r_bid_qty <= n_bid_qty;
            r_bid_ord <= n_bid_ord;
            r_ask_px  <= n_ask_px;
            r_ask_qty <= n_ask_qty;
            r_ask_ord <= n_ask_ord;
        end
    end

    // An empty side always shows zero price and quantity.
    a_bid_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bid_ord == '0) |-> (r_bid_px == '0 && r_bid_qty == '0))
        else $error("bid side empty but price or quantity nonzero");
    a_ask_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ask_ord == '0) |-> (r_ask_px == '0 && r_ask_qty == '0))
        else $error("ask side empty but price or quantity nonzero");
    a_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bid_ord != '0 && r_ask_ord != '0) |-> (r_bid_px < r_ask_px))
        else $error("book crossed");

endmodule

@@ src/tobf_queue.sv @@
`timescale 1ns / 1ps
module tobf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tobf_pkg::t_job      i_job,
    input  logic                i_pop,
    output tobf_pkg::t_job      o_head,
    output tobf_pkg::t_q_status o_status
);
    import tobf_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_BITS'(QUEUE_DEPTH)) |->
        (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

@@ src/tobf_back.sv @@
`timescale 1ns / 1ps
module tobf_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tobf_pkg::t_job                        i_head,
    input  tobf_pkg::t_q_status                   i_q,
    output logic                                  o_pop,
    input  logic                                  i_cfg_we,
    input  logic [tobf_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [tobf_pkg::CFG_BITS-1:0]         i_cfg_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output tobf_pkg::t_out_item                   o_item
);
    import tobf_pkg::*;

    logic [CFG_BITS-1:0]   r_interval;
    logic [CFG_BITS-1:0]   r_symbol;
    logic [SEQ_BITS-1:0]   r_seq;
    logic [CFG_BITS-1:0]   r_cnt;
    t_phase                r_state, n_state, step_state;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  load;
    logic [CFG_BITS-1:0]   cnt_inc;
    logic                  snap_due;
    logic [1:0]            msg_type;
    logic                  use_before;
    t_book                 book;
    t_out_item             msg;

    assign load     = !i_q.empty && (!r_out_valid || !i_stall);
    assign cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign snap_due = (cnt_inc >= r_interval);

    // Next message of the current event, as a step through its plan.
    always_comb begin
        unique case (r_state)
            PH_START: begin
                if (i_head.is_trade) begin
                    if (snap_due) begin
                        step_state = PH_SNAP_A;
                    end else if (i_head.updated) begin
                        step_state = PH_BOOK;
                    end else begin
                        step_state = PH_START;
                    end
                end else begin
                    step_state = snap_due ? PH_SNAP_B : PH_START;
                end
            end
            PH_SNAP_A: step_state = i_head.updated ? PH_BOOK : PH_START;
            PH_BOOK:   step_state = snap_due ? PH_SNAP_B : PH_START;
            PH_SNAP_B: step_state = PH_START;
            default:   step_state = PH_START;
        endcase
        n_state = load ? step_state : r_state;
    end

    always_comb begin
        unique case (r_state)
            PH_START:  msg_type = i_head.is_trade ? MSG_TRADE : MSG_BOOK;
            PH_SNAP_A: msg_type = MSG_SNAP;
            PH_BOOK:   msg_type = MSG_BOOK;
            PH_SNAP_B: msg_type = MSG_SNAP;
            default:   msg_type = MSG_SNAP;
        endcase
        // The snapshot right after a trade shows the book before the trade.
        use_before = (r_state == PH_SNAP_A);
        book       = use_before ? i_head.book_before : i_head.book_after;

        msg.msg_type     = msg_type;
        msg.msg_sequence = r_seq;
        msg.symbol       = r_symbol;
        if (msg_type == MSG_TRADE) begin
            msg.bid_price_out   = '0;
            msg.bid_qty_out     = '0;
            msg.ask_price_out   = '0;
            msg.ask_qty_out     = '0;
            msg.trade_price_out = i_head.trade_price;
            msg.trade_qty_out   = i_head.trade_qty;
            msg.trade_seq_out   = i_head.trade_seq;
        end else begin
            msg.bid_price_out   = book.bid_px;
            msg.bid_qty_out     = book.bid_qty;
            msg.ask_price_out   = book.ask_px;
            msg.ask_qty_out     = book.ask_qty;
            msg.trade_price_out = '0;
            msg.trade_qty_out   = '0;
            msg.trade_seq_out   = '0;
        end
        msg.last = (step_state == PH_START);
        o_pop    = load && (step_state == PH_START);
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= msg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= SNAP_INTERVAL_RESET;
            r_symbol    <= '0;
            r_seq       <= '0;
            r_cnt       <= '0;
            r_state     <= PH_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SNAP_INTERVAL: r_interval <= i_cfg_data;
                    CFG_SYMBOL_ID:     r_symbol   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
                r_seq       <= r_seq + 1'b1;
                if (msg_type != MSG_SNAP) begin
                    r_cnt <= snap_due ? '0 : cnt_inc;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_job_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != PH_START) |-> !i_q.empty)
        else $error("mid-event phase with no event queued");
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_seq == $past(r_seq) + 1'b1))
        else $error("feed sequence did not advance by one");
    a_snap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (step_state == PH_SNAP_A || step_state == PH_SNAP_B)) |=>
        (r_cnt == '0))
        else $error("message count not cleared before snapshot");

endmodule

@@ src/top_of_book_feed_tracker.sv @@
`timescale 1ns / 1ps
// Top-of-book feed tracker.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one exchange event per beat:
// a trade, an accepted order or a cancelled order. Output channel (o_out_valid /
// i_out_stall / o_out_data) carries feed messages: trade, top of book and snapshot,
// each numbered, with last set on the final message of an event.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); index 0 is
// the snapshot interval, index 1 the symbol id. Write it only while the block is idle.
// The front end updates the best bid and ask in the cycle an event is accepted and can
// take one event per cycle while the queue is not full. Events that produce messages go
// to a four-entry queue. The back end drains the queue at one message per cycle while
// the receiver does not stall; an event yields one to four messages, and the sustained rate is set by their number.
// With the queue empty, the first message of an event passes through the queue entry
// and then the output register. Ignored events produce no messages.
// When the receiver stalls, the output register holds its beat, the back end waits and
// the front end keeps accepting until the queue is full, then raises o_in_stall.
// Reset clears the book, the feed sequence and the snapshot count, sets the interval
// to 100 and the symbol id to 0; no clearing pass is needed.
module top_of_book_feed_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tobf_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tobf_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [tobf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [tobf_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import tobf_pkg::*;

    logic      push;
    logic      pop;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;

    tobf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_data),
        .i_q     (q_status),
        .o_push  (push),
        .o_job   (push_job)
    );

    tobf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    tobf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_q         (q_status),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_data)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import tobf_pkg::*;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int TIMEOUT_NS   = 3_000_000;

    // Predictor state: the book, the feed counters and the two registers.
    typedef struct packed {
        logic [PRICE_BITS-1:0] bid_px;
        logic [QTY_BITS-1:0]   bid_qty;
        logic [COUNT_BITS-1:0] bid_orders;
        logic [PRICE_BITS-1:0] ask_px;
        logic [QTY_BITS-1:0]   ask_qty;
        logic [COUNT_BITS-1:0] ask_orders;
        logic [SEQ_BITS-1:0]   next_seq;
        logic [15:0]           since_snap;
        logic [CFG_BITS-1:0]   snap_interval;
        logic [CFG_BITS-1:0]   symbol;
    } t_tracker;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    t_in_item  pending_events[$];
    t_out_item predicted_feed[$];
    t_tracker  live_book;
    t_tracker  gen_book;
    t_out_item want_msg;
    bit        msg_bad;
    int        mismatch_count = 0;
    int        send_idle_pct = 11;
    int        recv_idle_pct = 64;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;

    top_of_book_feed_tracker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_out_item announce(inout t_tracker st, input logic [1:0] msg_kind,
                                           input t_in_item ev);
        t_out_item m;
        m = '0;
        m.msg_type = msg_kind;
        m.msg_sequence = st.next_seq;
        m.symbol = st.symbol;
        if (msg_kind == MSG_TRADE) begin
            m.trade_price_out = ev.price;
            m.trade_qty_out = ev.quantity;
            m.trade_seq_out = ev.trade_seq_in;
        end else begin
            m.bid_price_out = st.bid_px;
            m.bid_qty_out = st.bid_qty;
            m.ask_price_out = st.ask_px;
            m.ask_qty_out = st.ask_qty;
        end
        st.next_seq = st.next_seq + 1'b1;
        return m;
    endfunction

    function automatic bit snapshot_due(inout t_tracker st);
        if (st.since_snap != 16'hFFFF) st.since_snap = st.since_snap + 1'b1;
        if (st.since_snap >= st.snap_interval) begin
            st.since_snap = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [QTY_BITS-1:0] add_saturating(input logic [QTY_BITS-1:0] a,
                                                           input logic [QTY_BITS-1:0] b);
        logic [QTY_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];
    endfunction

    // Takes quantity off one side of the book; an emptied side reads as zero.
    function automatic void drain_level(inout logic [PRICE_BITS-1:0] price,
                                        inout logic [QTY_BITS-1:0] qty,
                                        inout logic [COUNT_BITS-1:0] orders,
                                        input logic [QTY_BITS-1:0] amount,
                                        input bit remove_order);
        qty = (amount <= qty) ? qty - amount : '0;
        if (remove_order && orders != '0) orders = orders - 1'b1;
        if (orders == '0) begin
            price = '0;
            qty = '0;
        end
    endfunction

    function automatic void track_event(inout t_tracker st, input t_in_item ev,
                                        input bit record);
        t_out_item msgs[$];
        t_out_item tail;
        bit changed;
        changed = 1'b0;
        case (ev.kind)
            KIND_TRADE: begin
                msgs.push_back(announce(st, MSG_TRADE, ev));
                if (snapshot_due(st)) msgs.push_back(announce(st, MSG_SNAP, ev));
                if (st.bid_orders != '0 && st.bid_px == ev.price) begin
                    drain_level(st.bid_px, st.bid_qty, st.bid_orders, ev.quantity,
                                ev.resting_removed);
                    changed = 1'b1;
                end else if (st.ask_orders != '0 && st.ask_px == ev.price) begin
                    drain_level(st.ask_px, st.ask_qty, st.ask_orders, ev.quantity,
                                ev.resting_removed);
                    changed = 1'b1;
                end
            end
            KIND_ACCEPT: begin
                if (ev.price != '0 && ev.side != SIDE_SELL) begin
                    if (!(st.ask_orders != '0 && ev.price >= st.ask_px)) begin
                        if (st.bid_orders == '0 || ev.price > st.bid_px) begin
                            st.bid_px = ev.price;
                            st.bid_qty = ev.quantity;
                            st.bid_orders = COUNT_BITS'(1);
                            changed = 1'b1;
                        end else if (ev.price == st.bid_px) begin
                            st.bid_qty = add_saturating(st.bid_qty, ev.quantity);
                            if (st.bid_orders != '1) st.bid_orders = st.bid_orders + 1'b1;
                            changed = 1'b1;
                        end
                    end
                end else if (ev.price != '0) begin
                    if (!(st.bid_orders != '0 && ev.price <= st.bid_px)) begin
                        if (st.ask_orders == '0 || ev.price < st.ask_px) begin
                            st.ask_px = ev.price;
                            st.ask_qty = ev.quantity;
                            st.ask_orders = COUNT_BITS'(1);
                            changed = 1'b1;
                        end else if (ev.price == st.ask_px) begin
                            st.ask_qty = add_saturating(st.ask_qty, ev.quantity);
                            if (st.ask_orders != '1) st.ask_orders = st.ask_orders + 1'b1;
                            changed = 1'b1;
                        end
                    end
                end
            end
            KIND_CANCEL: begin
                if (ev.side != SIDE_SELL && st.bid_orders != '0 && ev.price == st.bid_px)
                begin
                    drain_level(st.bid_px, st.bid_qty, st.bid_orders, ev.quantity, 1'b1);
                    changed = 1'b1;
                end else if (ev.side == SIDE_SELL && st.ask_orders != '0
                             && ev.price == st.ask_px) begin
                    drain_level(st.ask_px, st.ask_qty, st.ask_orders, ev.quantity, 1'b1);
                    changed = 1'b1;
                end
            end
            default: ;
        endcase
        if (changed) begin
            msgs.push_back(announce(st, MSG_BOOK, ev));
            if (snapshot_due(st)) msgs.push_back(announce(st, MSG_SNAP, ev));
        end
        if (msgs.size() != 0) begin
            tail = msgs.pop_back();
            tail.last = 1'b1;
            msgs.push_back(tail);
        end
        if (record) begin
            foreach (msgs[i]) predicted_feed.push_back(msgs[i]);
        end
    endfunction

    function automatic t_in_item make_event(input logic [1:0] kind, input logic side,
                                            input logic [PRICE_BITS-1:0] price,
                                            input logic [QTY_BITS-1:0] qty,
                                            input logic removed,
                                            input logic [TSEQ_BITS-1:0] tseq);
        t_in_item ev;
        ev.kind = kind;
        ev.side = side;
        ev.price = price;
        ev.quantity = qty;
        ev.resting_removed = removed;
        ev.trade_seq_in = tseq;
        return ev;
    endfunction

    // Mostly well-formed traffic around the current top of book, with some noise.
    function automatic t_in_item next_event(input t_tracker g);
        t_in_item ev;
        int pick;
        logic [PRICE_BITS-1:0] anchor;
        bit use_bid;
        ev.side = 1'($urandom_range(1));
        ev.resting_removed = 1'($urandom_range(1));
        ev.trade_seq_in = $urandom;
        ev.quantity = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 400);
        use_bid = g.bid_orders != '0 && (g.ask_orders == '0 || $urandom_range(1) == 0);
        pick = $urandom_range(99);
        if (pick < 12) begin
            ev.kind = 2'($urandom_range(3));
            ev.price = ($urandom_range(3) == 0) ? '0 : $urandom;
            ev.quantity = $urandom;
        end else if (pick < 50) begin
            ev.kind = KIND_ACCEPT;
            if (ev.side == SIDE_SELL)
                anchor = (g.ask_orders != '0) ? g.ask_px :
                         (g.bid_orders != '0) ? g.bid_px + 3 : 1010;
            else
                anchor = (g.bid_orders != '0) ? g.bid_px :
                         (g.ask_orders != '0) ? g.ask_px - 3 : 1000;
            ev.price = anchor + $urandom_range(4) - 2;
        end else if (pick < 75) begin
            ev.kind = KIND_TRADE;
            ev.quantity = $urandom_range(0, 300);
            if (use_bid) ev.price = g.bid_px;
            else if (g.ask_orders != '0) ev.price = g.ask_px;
            else ev.price = $urandom_range(990, 1010);
            if ($urandom_range(7) == 0) ev.price = ev.price + 1;
        end else begin
            ev.kind = KIND_CANCEL;
            ev.quantity = $urandom_range(0, 300);
            if (use_bid) begin
                ev.side = ~SIDE_SELL;
                ev.price = g.bid_px;
            end else if (g.ask_orders != '0) begin
                ev.side = SIDE_SELL;
                ev.price = g.ask_px;
            end else begin
                ev.price = $urandom_range(990, 1010);
            end
            if ($urandom_range(7) == 0) ev.side = ~ev.side;
        end
        return ev;
    endfunction

    function automatic bit field_differs(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want === got) return 1'b0;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        return 1'b1;
    endfunction

    // The generator keeps its own copy of the book so that prices track the top.
    task automatic queue_event(input t_in_item ev);
        track_event(gen_book, ev, 1'b0);
        pending_events.push_back(ev);
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_event(next_event(gen_book));
    endtask

    task automatic settle();
        while (pending_events.size() != 0 || in_valid || predicted_feed.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SNAP_INTERVAL) begin
            live_book.snap_interval = value;
            gen_book.snap_interval = value;
        end else begin
            live_book.symbol = value;
            gen_book.symbol = value;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) track_event(live_book, in_data, 1'b1);
            if (!in_valid || !in_stall) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data <= pending_events.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (predicted_feed.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
                mismatch_count++;
            end else begin
                want_msg = predicted_feed.pop_front();
                msg_bad = 1'b0;
                msg_bad |= field_differs("msg_type", want_msg.msg_type, out_data.msg_type);
                msg_bad |= field_differs("msg_sequence", want_msg.msg_sequence,
                                         out_data.msg_sequence);
                msg_bad |= field_differs("symbol", want_msg.symbol, out_data.symbol);
                msg_bad |= field_differs("bid_price_out", want_msg.bid_price_out,
                                         out_data.bid_price_out);
                msg_bad |= field_differs("bid_qty_out", want_msg.bid_qty_out,
                                         out_data.bid_qty_out);
                msg_bad |= field_differs("ask_price_out", want_msg.ask_price_out,
                                         out_data.ask_price_out);
                msg_bad |= field_differs("ask_qty_out", want_msg.ask_qty_out,
                                         out_data.ask_qty_out);
                msg_bad |= field_differs("trade_price_out", want_msg.trade_price_out,
                                         out_data.trade_price_out);
                msg_bad |= field_differs("trade_qty_out", want_msg.trade_qty_out,
                                         out_data.trade_qty_out);
                msg_bad |= field_differs("trade_seq_out", want_msg.trade_seq_out,
                                         out_data.trade_seq_out);
                msg_bad |= field_differs("last", want_msg.last, out_data.last);
                if (msg_bad) mismatch_count++;
            end
        end
    end

    initial begin
        live_book = '0;
        live_book.snap_interval = SNAP_INTERVAL_RESET;
        gen_book = live_book;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed events with the reset register values.
        queue_event(make_event(KIND_UNKNOWN, 1'b1, '1, '1, 1'b1, '1));
        queue_event(make_event(KIND_TRADE, 1'b1, '1, '1, 1'b1, '1));
        queue_event(make_event(KIND_CANCEL, 1'b0, 0, 5, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 0, 10, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 1000, 10, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, SIDE_SELL, 1010, 20, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 1010, 4, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, SIDE_SELL, 1000, 4, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 999, 4, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, SIDE_SELL, 1011, 4, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 1005, 7, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 1005, '1, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, SIDE_SELL, 1008, 5, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, SIDE_SELL, 1008, 9, 1'b0, 0));
        queue_event(make_event(KIND_TRADE, 1'b0, 1005, 100, 1'b0, 32'h0000_0001));
        queue_event(make_event(KIND_TRADE, 1'b1, 1008, 3, 1'b1, 32'h0000_0002));
        queue_event(make_event(KIND_TRADE, 1'b0, 1234, 8, 1'b1, 32'h8000_0000));
        queue_event(make_event(KIND_CANCEL, SIDE_SELL, 1005, 1, 1'b0, 0));
        queue_event(make_event(KIND_CANCEL, 1'b0, 1005, '1, 1'b0, 0));
        queue_event(make_event(KIND_CANCEL, 1'b0, 1005, 1, 1'b0, 0));
        queue_event(make_event(KIND_TRADE, 1'b0, 1008, 50, 1'b1, 32'h0000_0003));
        queue_event(make_event(KIND_ACCEPT, SIDE_SELL, '1, 1, 1'b0, 0));
        queue_event(make_event(KIND_ACCEPT, 1'b0, 1, 1, 1'b0, 0));
        queue_event(make_event(KIND_CANCEL, SIDE_SELL, '1, 0, 1'b0, 0));
        settle();

        // Lowering the interval below the running count forces a snapshot at once.
        write_register(CFG_SNAP_INTERVAL, 16'd3);
        write_register(CFG_SYMBOL_ID, 16'hFFFF);
        queue_random(70);
        hold_requests = hold_requests + 1;
        settle();

        send_idle_pct = 64;
        recv_idle_pct = 11;
        write_register(CFG_SNAP_INTERVAL, 16'd0);
        write_register(CFG_SYMBOL_ID, 16'h5A3C);
        queue_random(50);
        settle();

        write_register(CFG_SNAP_INTERVAL, 16'hFFFF);
        write_register(CFG_SYMBOL_ID, 16'h0000);
        queue_random(45);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_SNAP_INTERVAL, 16'd1);
        write_register(CFG_SYMBOL_ID, 16'($urandom_range(1, 16'hFFFE)));
        queue_random(40);
        settle();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("%0t: timeout with %0d beats outstanding", $time, predicted_feed.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tobf_pkg.sv
src/tobf_front.sv
src/tobf_queue.sv
src/tobf_back.sv
src/top_of_book_feed_tracker.sv
dv/tb.sv
